// ===== hdl/ccrc_pkg.sv =====
`timescale 1ns / 1ps

package ccrc_pkg;

	// Fixed field widths of the configuration port and the channels.
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CRC_WIDTH_W = 6;
	localparam int DATA_W      = 8;
	localparam int CRC_OUT_W   = 32;

	// Default upper bound on the CRC width.
	localparam int DEF_MAX_WIDTH = 32;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_WIDTH      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_VALUE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FINAL_XOR      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_INPUT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_OUTPUT = 3'd5;

	// Reset values (CRC-32 as used by Ethernet).
	localparam logic [CRC_WIDTH_W-1:0] RST_CRC_WIDTH  = 6'd32;
	localparam logic [CFG_DATA_W-1:0]  RST_POLYNOMIAL = 32'h04C1_1DB7;
	localparam logic [CFG_DATA_W-1:0]  RST_INIT_VALUE = 32'hFFFF_FFFF;
	localparam logic [CFG_DATA_W-1:0]  RST_FINAL_XOR  = 32'hFFFF_FFFF;
	localparam logic                   RST_REFLECT_IN  = 1'b1;
	localparam logic                   RST_REFLECT_OUT = 1'b1;

	// The smallest width the engine runs at.
	localparam int MIN_WIDTH = 4;

	typedef logic [DATA_W-1:0]    data_t;
	typedef logic [CRC_OUT_W-1:0] crc_out_t;

	function automatic data_t reverse_byte(input data_t b);
		data_t r;
		for (int i = 0; i < DATA_W; i++) begin
			r[i] = b[DATA_W-1-i];
		end
		return r;
	endfunction

endpackage

// ===== hdl/ccrc_in_if.sv =====
`timescale 1ns / 1ps

interface ccrc_in_if;
	import ccrc_pkg::*;

	logic  valid;
	logic  ready;
	data_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/ccrc_out_if.sv =====
`timescale 1ns / 1ps

interface ccrc_out_if;
	import ccrc_pkg::*;

	logic     valid;
	logic     ready;
	crc_out_t crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== hdl/configurable_crc_engine_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload                         Transfer when
// in_ch     sink       data_byte[7:0], last_byte       in_ch.valid && in_ch.ready
// out_ch    source     crc_value[31:0]                 out_ch.valid && out_ch.ready
// cfg       write      cfg_index[2:0], cfg_wdata[31:0] cfg_wr_en
//
// One byte is taken per clock unless a last byte waits on a stalled output. The
// byte goes into an input register, the eight bit steps are folded in by XOR
// logic as it leaves that register, and on the last byte of a message the CRC
// lands in the result register, whose flag drives output valid. The CRC
// register feeds back on itself through that XOR logic, which is what sets
// the one-byte-per-clock figure.
// Reset clears both stages and reloads the configuration defaults (CRC-32).
// A stalled output only holds the input stage when it carries a last byte.

module configurable_crc_engine_core #(
	parameter int MAX_WIDTH = ccrc_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ccrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ccrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ccrc_in_if.sink                           in_ch,
	ccrc_out_if.source                        out_ch
);
	import ccrc_pkg::*;

	// Wide enough to hold MAX_WIDTH itself and the raw width register.
	localparam int WW = ($clog2(MAX_WIDTH + 1) > CRC_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) + 1 : CRC_WIDTH_W + 1;

	// Configuration registers.
	logic [CRC_WIDTH_W-1:0] crc_width_q;
	logic [CFG_DATA_W-1:0]  polynomial_q;
	logic [CFG_DATA_W-1:0]  init_value_q;
	logic [CFG_DATA_W-1:0]  final_xor_q;
	logic                   reflect_in_q;
	logic                   reflect_out_q;

	// Input stage, message state and result register.
	logic                 valid_s1;
	data_t                data_s1;
	logic                 last_s1;
	logic [MAX_WIDTH-1:0] crc_q;
	logic                 start_q;
	logic                 out_valid_q;
	crc_out_t             out_crc_q;

	logic adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_width_q   <= RST_CRC_WIDTH;
			polynomial_q  <= RST_POLYNOMIAL;
			init_value_q  <= RST_INIT_VALUE;
			final_xor_q   <= RST_FINAL_XOR;
			reflect_in_q  <= RST_REFLECT_IN;
			reflect_out_q <= RST_REFLECT_OUT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CRC_WIDTH:      crc_width_q   <= cfg_wdata[CRC_WIDTH_W-1:0];
				REG_POLYNOMIAL:     polynomial_q  <= cfg_wdata;
				REG_INIT_VALUE:     init_value_q  <= cfg_wdata;
				REG_FINAL_XOR:      final_xor_q   <= cfg_wdata;
				REG_REFLECT_INPUT:  reflect_in_q  <= cfg_wdata[0];
				REG_REFLECT_OUTPUT: reflect_out_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Effective width, clamped to the range the engine supports.
	logic [WW-1:0] raw_w;
	logic [WW-1:0] eff_w;
	logic [WW-1:0] shamt;

	always_comb begin
		raw_w = WW'(crc_width_q);
		priority if (raw_w < WW'(MIN_WIDTH)) begin
			eff_w = WW'(MIN_WIDTH);
		end else if (raw_w > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = raw_w;
		end
		shamt = WW'(MAX_WIDTH) - eff_w;
	end

	// Configuration values brought to MAX_WIDTH bits.
	logic [MAX_WIDTH+CFG_DATA_W-1:0] poly_x;
	logic [MAX_WIDTH+CFG_DATA_W-1:0] init_x;
	logic [MAX_WIDTH+CFG_DATA_W-1:0] fxor_x;
	logic [MAX_WIDTH-1:0]            mask;

	assign poly_x = {{MAX_WIDTH{1'b0}}, polynomial_q};
	assign init_x = {{MAX_WIDTH{1'b0}}, init_value_q};
	assign fxor_x = {{MAX_WIDTH{1'b0}}, final_xor_q};
	assign mask   = {MAX_WIDTH{1'b1}} >> shamt;

	// The register is kept right-justified and aligned to the top bit for
	// the bit steps, so the feedback tap sits at a fixed position.
	logic [MAX_WIDTH-1:0] poly_al;
	logic [MAX_WIDTH-1:0] crc_cur;
	logic [MAX_WIDTH-1:0] crc_al;
	logic [MAX_WIDTH-1:0] crc_next_al;
	logic [MAX_WIDTH-1:0] crc_next;
	logic [MAX_WIDTH-1:0] crc_rev;
	logic [MAX_WIDTH-1:0] crc_res;
	logic [MAX_WIDTH+CRC_OUT_W-1:0] res_x;
	data_t                byte_in;
	logic                 fb;

	always_comb begin
		poly_al = (poly_x[MAX_WIDTH-1:0] & mask) << shamt;
		crc_cur = start_q ? init_x[MAX_WIDTH-1:0] : crc_q;
		crc_al  = (crc_cur & mask) << shamt;
		byte_in = reflect_in_q ? reverse_byte(data_s1) : data_s1;

		crc_next_al = crc_al;
		for (int i = 0; i < DATA_W; i++) begin
			fb          = crc_next_al[MAX_WIDTH-1] ^ byte_in[DATA_W-1-i];
			crc_next_al = {crc_next_al[MAX_WIDTH-2:0], 1'b0} ^ (fb ? poly_al : '0);
		end
		crc_next = crc_next_al >> shamt;

		// Reversing the top-aligned value reflects it over the active width.
		for (int k = 0; k < MAX_WIDTH; k++) begin
			crc_rev[k] = crc_next_al[MAX_WIDTH-1-k];
		end
		crc_res = ((reflect_out_q ? crc_rev : crc_next) ^ fxor_x[MAX_WIDTH-1:0]) & mask;
		res_x   = {{CRC_OUT_W{1'b0}}, crc_res};
	end

	// A last byte needs room in the result register; other bytes always move.
	assign adv_s1      = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			start_q     <= 1'b1;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv_s1) begin
				crc_q   <= crc_next;
				start_q <= last_s1;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
		if (adv_s1 && last_s1) begin
			out_crc_q <= res_x[CRC_OUT_W-1:0];
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.crc_value = out_crc_q;

	// A last byte leaving the input stage always produces a result.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("last byte did not produce a result");

	// A byte that is not last leaves the engine mid-message.
	a_mid_message: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !last_s1 |=> !start_q)
		else $error("message state lost after a middle byte");

	// The input stage only waits behind a full, stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> last_s1 && out_valid_q && !out_ch.ready)
		else $error("input stage stalled without cause");

	// An accepted byte always occupies the input stage next cycle.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> valid_s1)
		else $error("accepted byte was dropped");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the parametric CRC engine.
//
// The bench keeps its own copy of the six configuration registers and of the
// engine state: the running CRC and the flag that marks the start of a
// message. Every byte transfer on the input channel is folded into that copy
// at the clock edge where it happens. When the byte closes a message, the
// finished CRC is queued. The output monitor pops the oldest queued CRC on
// every output transfer and compares it with what the engine delivered.
//
// Configuration is only changed while the engine is quiet. The input valid
// is dropped, every queued CRC must have come out, and a drain wait follows
// so that a byte which closes no message has also been folded in. Quiet
// points can fall in the middle of a message, which covers a width or
// polynomial change between two bytes of one message.

module tb_top;
	import ccrc_pkg::*;

	// Cycles allowed after the last expected CRC for the pipeline to empty.
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_W        = DEF_MAX_WIDTH;

	// Indexes past the last register. A write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

	localparam int RANDOM_PHASES    = 14;
	localparam int BYTES_PER_PHASE  = 76;
	localparam int BURST_BYTES      = 40;
	localparam int HOLD_OFF_CYCLES  = 200;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	ccrc_in_if  in_ch ();
	ccrc_out_if out_ch ();

	configurable_crc_engine_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow of the configuration registers, as last written.
	logic [CRC_WIDTH_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0]  poly_reg;
	logic [CFG_DATA_W-1:0]  init_reg;
	logic [CFG_DATA_W-1:0]  xor_reg;
	logic                   refl_in_reg;
	logic                   refl_out_reg;

	// Shadow of the engine state. The running CRC is kept at 64 bits so the
	// arithmetic holds for any MAX_WIDTH the engine may be built with.
	logic [63:0] crc_state;
	logic        msg_start;

	// CRCs that have been predicted and not yet seen on the output.
	crc_out_t pending_crcs[$];

	int unsigned mismatch_count;
	int unsigned rx_hold_left;
	int unsigned rx_stall_left;
	int unsigned bytes_left_in_msg;
	bit          tx_idle_on;
	bit          rx_idle_on;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Reverses the low n bits of v.
	function automatic logic [63:0] mirror_bits(input logic [63:0] v, input int unsigned n);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < n; i++) begin
			r = {r[62:0], v[i]};
		end
		return r;
	endfunction

	// Folds one accepted byte into the shadow state and queues the finished
	// CRC when the byte closes a message. The width is clamped into the range
	// the engine supports, and every register is cut to that width before use.
	function automatic void fold_byte(input data_t b, input logic last);
		int unsigned w;
		logic [63:0] mask;
		logic [63:0] poly_w;
		logic [63:0] crc;
		data_t       bits;
		logic        top;
		w = 32'(width_reg);
		if (w < MIN_WIDTH) w = MIN_WIDTH;
		if (w > MAX_W) w = MAX_W;
		mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		poly_w = {32'd0, poly_reg} & mask;
		if (msg_start) crc_state = {32'd0, init_reg};
		crc = crc_state & mask;
		bits = refl_in_reg ? data_t'(mirror_bits({56'd0, b}, DATA_W)) : b;
		// Message bits enter MSB first, one polynomial step per bit.
		for (int i = 0; i < DATA_W; i++) begin
			top = crc[w-1] ^ bits[DATA_W-1-i];
			crc = (crc << 1) & mask;
			if (top) crc = crc ^ poly_w;
		end
		crc_state = crc;
		msg_start = last;
		if (last) begin
			if (refl_out_reg) crc = mirror_bits(crc, w);
			crc = (crc ^ {32'd0, xor_reg}) & mask;
			pending_crcs.push_back(crc[CRC_OUT_W-1:0]);
		end
	endfunction

	// Mirrors a register write into the shadow. Spare indexes are dropped.
	function automatic void shadow_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_CRC_WIDTH: begin
				width_reg = val[CRC_WIDTH_W-1:0];
			end
			REG_POLYNOMIAL: begin
				poly_reg = val;
			end
			REG_INIT_VALUE: begin
				init_reg = val;
			end
			REG_FINAL_XOR: begin
				xor_reg = val;
			end
			REG_REFLECT_INPUT: begin
				refl_in_reg = val[0];
			end
			REG_REFLECT_OUTPUT: begin
				refl_out_reg = val[0];
			end
			default: begin
			end
		endcase
	endfunction

	// Stall length for either side: mostly short, some medium, a few long.
	function automatic int unsigned stall_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned tx_gap();
		if (!tx_idle_on) return 0;
		if ($urandom_range(0, 99) < 55) return 0;
		return stall_len();
	endfunction

	// Message length: many single-byte messages, most short, some long.
	function automatic int unsigned msg_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) return 1;
		if (r < 80) return $urandom_range(2, 8);
		return $urandom_range(9, 24);
	endfunction

	// Offers one byte after an optional gap and waits for its transfer. The
	// valid stays high afterwards so that back-to-back bytes need no toggle.
	// Entered and left just after a falling edge.
	task automatic push_byte(input data_t b, input logic last);
		int unsigned gap;
		gap = tx_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		fold_byte(b, last);
		@(negedge clk);
	endtask

	// Sends a random byte that belongs to a running random message.
	task automatic push_stream_byte();
		if (bytes_left_in_msg == 0) bytes_left_in_msg = msg_len();
		push_byte(data_t'($urandom_range(0, 255)), bytes_left_in_msg == 1);
		bytes_left_in_msg--;
	endtask

	// Brings the engine to a quiet point: input idle, every CRC delivered,
	// and the last byte folded in even if it closed no message.
	task automatic settle_engine();
		in_ch.valid <= 1'b0;
		while (pending_crcs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		shadow_write(idx, val);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all six registers. With noisy set, the unused upper bits of the
	// width and reflect words carry random junk and the spare indexes get
	// written too; none of that may change the result.
	task automatic load_profile(input logic [CRC_WIDTH_W-1:0] w, input logic [31:0] poly,
		input logic [31:0] init, input logic [31:0] fxor, input logic ri, input logic ro,
		input bit noisy);
		logic [31:0] junk;
		junk = noisy ? $urandom : 32'd0;
		write_reg(REG_CRC_WIDTH, (junk & ~32'h3F) | {26'd0, w});
		write_reg(REG_POLYNOMIAL, poly);
		write_reg(REG_INIT_VALUE, init);
		write_reg(REG_FINAL_XOR, fxor);
		write_reg(REG_REFLECT_INPUT, (junk & ~32'h1) | {31'd0, ri});
		write_reg(REG_REFLECT_OUTPUT, ({junk[15:0], junk[31:16]} & ~32'h1) | {31'd0, ro});
		if (noisy) begin
			write_reg(SPARE_INDEX_LO, $urandom);
			write_reg(SPARE_INDEX_HI, $urandom);
		end
	endtask

	function automatic logic [31:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h0000_0000;
		if (r == 1) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic random_profile();
		logic [CRC_WIDTH_W-1:0] w;
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: w = CRC_WIDTH_W'($urandom_range(0, MIN_WIDTH - 1));
			1: w = CRC_WIDTH_W'($urandom_range(MAX_W + 1, 63));
			2: w = CRC_WIDTH_W'(MIN_WIDTH);
			3: w = CRC_WIDTH_W'(MAX_W);
			4: w = 6'd16;
			default: w = CRC_WIDTH_W'($urandom_range(MIN_WIDTH, 8));
		endcase
		load_profile(w, pick_word(), pick_word(), pick_word(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
	endtask

	// The reset configuration is CRC-32. The standard check string "123456789"
	// is sent without any register write and checked against the shadow model.
	task automatic test_reset_defaults();
		for (int i = 1; i <= 9; i++) begin
			push_byte(data_t'(8'h30 + i), i == 9);
		end
		settle_engine();
	endtask

	// Extremes of every register and of the data byte, mostly as single-byte
	// messages. A width below the minimum must act as the minimum, and one
	// above the maximum as the maximum. Bits of the polynomial, init value
	// and final XOR above the width must be ignored.
	task automatic test_register_extremes();
		load_profile(6'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		settle_engine();
		load_profile(6'd63, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		push_byte(8'h80, 1'b1);
		push_byte(8'h01, 1'b1);
		settle_engine();
		load_profile(6'd4, 32'hFFFF_FFF3, 32'hFFFF_FFF5, 32'h1234_567A, 1'b0, 1'b1, 1'b0);
		push_byte(8'hA5, 1'b1);
		push_byte(8'h5A, 1'b1);
		settle_engine();
		// CRC-8 with everything plain: a zero byte must give a zero CRC.
		load_profile(6'd8, 32'h0000_0007, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7E, 1'b1);
		settle_engine();
	endtask

	// Registers change between two bytes of one message. The running CRC is
	// cut to the new width, and the new init value waits for the next message.
	task automatic test_midstream_reconfig();
		load_profile(6'd32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		push_byte(8'hDE, 1'b0);
		push_byte(8'hAD, 1'b0);
		push_byte(8'hBE, 1'b0);
		settle_engine();
		write_reg(REG_CRC_WIDTH, 32'd16);
		write_reg(REG_POLYNOMIAL, 32'h0000_1021);
		write_reg(REG_INIT_VALUE, 32'h0000_0000);
		push_byte(8'hEF, 1'b0);
		settle_engine();
		write_reg(REG_CRC_WIDTH, 32'd32);
		write_reg(REG_REFLECT_INPUT, 32'd0);
		push_byte(8'h42, 1'b1);
		push_byte(8'h42, 1'b1);
		settle_engine();
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering single-byte messages back to back, so the pipeline fills and
	// the input must stall without losing or repeating a transfer.
	task automatic test_output_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		load_profile(6'd16, 32'h0000_8005, 32'h0000_FFFF, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
		@(posedge clk);
		rx_hold_left = HOLD_OFF_CYCLES;
		@(negedge clk);
		for (int i = 0; i < BURST_BYTES; i++) begin
			push_byte(data_t'($urandom_range(0, 255)), 1'b1);
		end
		settle_engine();
	endtask

	// Random messages under random configurations. Each phase picks its own
	// idling mix, including phases with none at all. A phase may end in the
	// middle of a message, which then goes on under the next configuration.
	task automatic test_random_messages();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_idle_on = p[0];
			rx_idle_on = p[1];
			random_profile();
			for (int i = 0; i < BYTES_PER_PHASE; i++) begin
				push_stream_byte();
			end
			settle_engine();
		end
		// Close any open message so that its CRC is checked too.
		while (bytes_left_in_msg != 0) push_stream_byte();
		settle_engine();
	endtask

	// Receiver: a long hold-off when one is asked for, otherwise random
	// stalls while idling is on, otherwise always ready.
	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			out_ch.ready <= 1'b0;
			rx_hold_left--;
		end else begin
			if (rx_stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
				rx_stall_left = stall_len();
			end
			if (rx_stall_left != 0) begin
				out_ch.ready <= 1'b0;
				rx_stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Output monitor: each transfer must match the oldest predicted CRC.
	always @(posedge clk) begin
		crc_out_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_crcs.size() == 0) begin
				mismatch_count++;
				$display("%0t: crc_value with none expected: expected none, actual %08h",
					$time, out_ch.crc_value);
			end else begin
				want = pending_crcs.pop_front();
				if (out_ch.crc_value !== want) begin
					mismatch_count++;
					$display("%0t: crc_value mismatch: expected %08h, actual %08h",
						$time, want, out_ch.crc_value);
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("configurable_crc_engine_core verification failed");
		$finish;
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = REG_CRC_WIDTH;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.data_byte   = '0;
		in_ch.last_byte   = 1'b0;
		out_ch.ready      = 1'b0;
		width_reg         = RST_CRC_WIDTH;
		poly_reg          = RST_POLYNOMIAL;
		init_reg          = RST_INIT_VALUE;
		xor_reg           = RST_FINAL_XOR;
		refl_in_reg       = RST_REFLECT_IN;
		refl_out_reg      = RST_REFLECT_OUT;
		crc_state         = '0;
		msg_start         = 1'b1;
		mismatch_count    = 0;
		rx_hold_left      = 0;
		rx_stall_left     = 0;
		bytes_left_in_msg = 0;
		tx_idle_on        = 1'b0;
		rx_idle_on        = 1'b0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_register_extremes();
		test_midstream_reconfig();
		test_output_backpressure();
		test_random_messages();

		settle_engine();
		if (mismatch_count == 0) begin
			$display("configurable_crc_engine_core verification clean");
		end else begin
			$display("configurable_crc_engine_core verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ccrc_pkg.sv
hdl/ccrc_in_if.sv
hdl/ccrc_out_if.sv
hdl/configurable_crc_engine_core.sv
verif/tb_top.sv
